// ----- rtl/core/pcc_pkg.sv -----
package pcc_pkg;

    localparam int SYMBOLS_DEF = 8;
    localparam int WORD_W      = 32;
    localparam int NIB_W       = 4;
    localparam int NIBS        = WORD_W / NIB_W;
    localparam int ACT_W       = 2;
    localparam int DIM_W       = 4;

    localparam logic [ACT_W-1:0] ACT_TO_CODE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TO_PERM   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NEIGHBOUR = 2'd2;

    // One word as it moves down the pipeline.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] result;
        logic              err;
    } pcc_item_t;

    // Nibble k of a word; positions past the word read as zero.
    function automatic logic [NIB_W-1:0] nib_get(logic [WORD_W-1:0] w, int k);
        logic [NIB_W-1:0] v;
        v = '0;
        for (int n = 0; n < NIBS; n++) begin
            if (n == k) begin
                v = w[NIB_W*n +: NIB_W];
            end
        end
        return v;
    endfunction

    // Write nibble k of a word; positions past the word are dropped.
    function automatic logic [WORD_W-1:0] nib_put(logic [WORD_W-1:0] w, int k,
                                                  logic [NIB_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = w;
        for (int n = 0; n < NIBS; n++) begin
            if (n == k) begin
                r[NIB_W*n +: NIB_W] = v;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pcc_front.sv -----
module pcc_front
    import pcc_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid_i,
    output logic              in_ready_o,
    input  logic [ACT_W-1:0]  action_i,
    input  logic [WORD_W-1:0] word_i,
    input  logic [DIM_W-1:0]  dimension_i,
    output logic              out_valid_o,
    input  logic              out_ready_i,
    output pcc_item_t         out_item_o
);

    logic              valid_reg;
    pcc_item_t         item_reg;
    pcc_item_t         item_next;
    logic              codes_ok;
    logic              dim_ok;
    logic [DIM_W-1:0]  i_idx;
    logic [DIM_W-1:0]  j_idx;
    logic [NIB_W-1:0]  ci;
    logic [NIB_W-1:0]  cj;
    logic [NIB_W-1:0]  ni;
    logic [NIB_W-1:0]  nj;
    logic [NIB_W-1:0]  d;
    logic [WORD_W-1:0] nbr_word;

    // Digit check, dimension check and the adjacent-transposition rewrite.
    always_comb begin
        codes_ok = 1'b1;
        for (int k = 0; k < SYMBOLS; k++) begin
            d = nib_get(word_i, k);
            if (d == '0 || {1'b0, d} > 5'(k + 1)) begin
                codes_ok = 1'b0;
            end
        end

        dim_ok = (dimension_i >= DIM_W'(2)) && (dimension_i <= DIM_W'(SYMBOLS));
        i_idx  = dimension_i - DIM_W'(2);
        j_idx  = dimension_i - DIM_W'(1);

        ci = '0;
        cj = '0;
        for (int k = 0; k < NIBS; k++) begin
            if (DIM_W'(k) == i_idx) begin
                ci = word_i[NIB_W*k +: NIB_W];
            end
            if (DIM_W'(k) == j_idx) begin
                cj = word_i[NIB_W*k +: NIB_W];
            end
        end

        if (ci < cj) begin
            ni = cj - NIB_W'(1);
            nj = ci;
        end else begin
            ni = cj;
            nj = ci + NIB_W'(1);
        end

        nbr_word = '0;
        for (int k = 0; k < NIBS; k++) begin
            if (k < SYMBOLS) begin
                d = word_i[NIB_W*k +: NIB_W];
            end else begin
                d = '0;
            end
            if (DIM_W'(k) == i_idx) begin
                d = ni;
            end else if (DIM_W'(k) == j_idx) begin
                d = nj;
            end
            nbr_word[NIB_W*k +: NIB_W] = d;
        end

        item_next.action = action_i;
        item_next.word   = word_i;
        item_next.result = '0;
        case (action_i)
            ACT_TO_CODE: begin
                item_next.err = 1'b0;
            end
            ACT_TO_PERM: begin
                item_next.err = !codes_ok;
            end
            ACT_NEIGHBOUR: begin
                item_next.err    = !codes_ok || !dim_ok;
                item_next.result = nbr_word;
            end
            default: begin
                item_next.err = 1'b1;
            end
        endcase
    end

    assign in_ready_o  = !valid_reg || out_ready_i;
    assign out_valid_o = valid_reg;
    assign out_item_o  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready_o) begin
            valid_reg <= in_valid_i;
        end
        if (in_ready_o && in_valid_i) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/core/pcc_stage.sv -----
module pcc_stage
    import pcc_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEF,
    parameter int POS     = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid_i,
    output logic               in_ready_o,
    input  pcc_item_t          in_item_i,
    input  logic [SYMBOLS-1:0] used_i,
    output logic               out_valid_o,
    input  logic               out_ready_i,
    output pcc_item_t          out_item_o,
    output logic [SYMBOLS-1:0] used_o
);

    logic               valid_reg;
    pcc_item_t          item_reg;
    pcc_item_t          item_next;
    logic [SYMBOLS-1:0] used_reg;
    logic [SYMBOLS-1:0] used_next;
    logic [NIB_W-1:0]   s;
    logic               hit;
    logic               taken;
    logic [NIB_W-1:0]   greater;
    logic [NIB_W-1:0]   idx;
    logic [NIB_W-1:0]   seen;
    logic               found;
    logic [NIB_W-1:0]   pick;
    logic [NIB_W-1:0]   sym;
    logic [NIB_W-1:0]   digit;

    // Symbols are held as a mask of used ones; the descending list of unused
    // symbols is the mask read from the top symbol down.
    always_comb begin
        s       = nib_get(in_item_i.word, POS);
        hit     = 1'b0;
        taken   = 1'b0;
        greater = '0;
        for (int v = 1; v <= SYMBOLS; v++) begin
            if (s == NIB_W'(v)) begin
                hit   = 1'b1;
                taken = used_i[v-1];
            end
            if (NIB_W'(v) > s && !used_i[v-1]) begin
                greater = greater + NIB_W'(1);
            end
        end

        idx   = s - NIB_W'(1);
        seen  = '0;
        found = 1'b0;
        pick  = '0;
        for (int v = SYMBOLS; v >= 1; v--) begin
            if (!used_i[v-1]) begin
                if (!found && seen == idx) begin
                    found = 1'b1;
                    pick  = NIB_W'(v);
                end
                seen = seen + NIB_W'(1);
            end
        end

        item_next = in_item_i;
        sym       = '0;
        digit     = '0;
        case (in_item_i.action)
            ACT_TO_CODE: begin
                sym   = s;
                digit = greater + NIB_W'(1);
                if (!hit || taken) begin
                    item_next.err = 1'b1;
                end
            end
            ACT_TO_PERM: begin
                sym   = pick;
                digit = pick;
            end
            default: begin
                sym = '0;
            end
        endcase

        if (in_item_i.action == ACT_TO_CODE || in_item_i.action == ACT_TO_PERM) begin
            item_next.result = nib_put(in_item_i.result, POS, digit);
        end

        used_next = used_i;
        for (int v = 1; v <= SYMBOLS; v++) begin
            if (sym == NIB_W'(v)) begin
                used_next[v-1] = 1'b1;
            end
        end
    end

    assign in_ready_o  = !valid_reg || out_ready_i;
    assign out_valid_o = valid_reg;
    assign out_item_o  = item_reg;
    assign used_o      = used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready_o) begin
            valid_reg <= in_valid_i;
        end
        if (in_ready_o && in_valid_i) begin
            item_reg <= item_next;
            used_reg <= used_next;
        end
    end

endmodule

// ----- rtl/core/permutation_code_convert_unit.sv -----
// Permutation / factorial-base code converter.
// Each input word on the s_ channel carries a packed 4-bit-per-position
// permutation or code in s_tdata[31:0], a neighbour dimension in
// s_tdata[35:32], and the action in s_tuser: 0 turns a permutation into its
// code, 1 turns a code into its permutation, 2 turns a code into the code of
// the neighbour across positions dimension-2 and dimension-1.
// Each result word on the m_ channel carries the converted word in m_tdata
// and an error flag in m_tuser; an invalid symbol, digit, dimension or action
// raises the flag and returns an all-zero word.
// The pipeline has one decode stage that checks digits and builds the
// neighbour code, one stage per position from the last position
// back to position 0 that resolves one symbol against the mask of symbols
// already used, and one output register.
// Throughput is one word per clock while m_tready is high; every stage holds
// its own valid bit, so a new word is accepted whenever the pipeline is not full.
// When the receiver holds m_tready low the pipeline fills up stage by stage
// and then drops s_tready; nothing is lost or repeated.
// A synchronous low level on aresetn empties every stage.
module permutation_code_convert_unit
    import pcc_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // word [31:0], dimension [35:32], zero [39:36]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_word [31:0]
    output logic [0:0]  m_tuser    // error [0]
);

    // Index 0 is the decode stage; index n is the stage for position SYMBOLS-n.
    logic               stg_valid [0:SYMBOLS];
    logic               stg_ready [0:SYMBOLS];
    pcc_item_t          stg_item  [0:SYMBOLS];
    logic [SYMBOLS-1:0] stg_used  [0:SYMBOLS];

    logic               m_valid_reg;
    logic [WORD_W-1:0]  m_data_reg;
    logic               m_err_reg;
    logic               out_ready;

    pcc_front #(
        .SYMBOLS (SYMBOLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid_i  (s_tvalid),
        .in_ready_o  (s_tready),
        .action_i    (s_tuser),
        .word_i      (s_tdata[WORD_W-1:0]),
        .dimension_i (s_tdata[WORD_W +: DIM_W]),
        .out_valid_o (stg_valid[0]),
        .out_ready_i (stg_ready[0]),
        .out_item_o  (stg_item[0])
    );

    // Nothing is used before the last position is resolved.
    assign stg_used[0] = '0;

    // Position 0 is the last to resolve; its used mask is not read further on.
    for (genvar n = 1; n <= SYMBOLS; n++) begin : g_pos
        pcc_stage #(
            .SYMBOLS (SYMBOLS),
            .POS     (SYMBOLS - n)
        ) u_stage (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_valid_i  (stg_valid[n-1]),
            .in_ready_o  (stg_ready[n-1]),
            .in_item_i   (stg_item[n-1]),
            .used_i      (stg_used[n-1]),
            .out_valid_o (stg_valid[n]),
            .out_ready_i (stg_ready[n]),
            .out_item_o  (stg_item[n]),
            .used_o      (stg_used[n])
        );
    end

    // Output register: an error word is forced to zero here.
    assign out_ready          = !m_valid_reg || m_tready;
    assign stg_ready[SYMBOLS] = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= stg_valid[SYMBOLS];
        end
        if (out_ready && stg_valid[SYMBOLS]) begin
            m_data_reg <= stg_item[SYMBOLS].err ? '0 : stg_item[SYMBOLS].result;
            m_err_reg  <= stg_item[SYMBOLS].err;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_err_reg;

endmodule
